// ===== rtl/tksel_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Top-k score selector package
// Shared word types, codes, constants and the ranking function.
// ----------------------------------------------------------------------------
package tksel_pkg;

  // Default depth of the cell chain.
  localparam int MAX_KEEP_DEF = 16;

  // Reset value of the keep count register.
  localparam logic [4:0] KEEP_COUNT_RST = 5'd16;

  // Operation codes of an input word.
  typedef enum logic {
    OP_OFFER = 1'b0,
    OP_FLUSH = 1'b1
  } op_t;

  // Input word: one candidate offer or a flush command.
  typedef struct packed {
    op_t         op;
    logic [30:0] doc_id;
    logic [31:0] score;
  } cand_word_t;

  // Output word: one ranked result of a flush.
  typedef struct packed {
    logic [30:0] out_doc_id;
    logic [31:0] out_score;
    logic        last;
  } res_word_t;

  // One kept entry of the chain.
  typedef struct packed {
    logic [31:0] score;
    logic [30:0] doc_id;
  } entry_t;

  // Per-cycle control broadcast to every cell.
  typedef struct packed {
    logic offer;
    logic trim;
    logic shift_up;
  } cell_ctl_t;

  // Selector sequencer states.
  typedef enum logic {
    ST_IDLE  = 1'b0,
    ST_DRAIN = 1'b1
  } sel_state_t;

  // True when a ranks strictly better than b: higher score, then lower id.
  function automatic logic ranks_above(entry_t a, entry_t b);
    logic res;
    if (a.score != b.score) begin
      res = (a.score > b.score);
    end else begin
      res = (a.doc_id < b.doc_id);
    end
    return res;
  endfunction

endpackage

// ===== rtl/tksel_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Top-k selector cell
// One slot of the sorted chain: keeps an entry, inserts, shifts down on
// insertion and shifts up while the chain is drained.
// ----------------------------------------------------------------------------
module tksel_cell (
  input  logic               clk,
  input  logic               rst,
  input  tksel_pkg::cell_ctl_t ctl,
  input  tksel_pkg::entry_t  cand,
  input  logic               in_range,
  input  logic               prev_take,
  input  logic               prev_valid,
  input  tksel_pkg::entry_t  prev_entry,
  input  logic               next_valid,
  input  tksel_pkg::entry_t  next_entry,
  output logic               take,
  output logic               valid,
  output tksel_pkg::entry_t  entry
);
  import tksel_pkg::*;

  // The candidate belongs at or above this slot.
  assign take = ~valid | ranks_above(cand, entry);

  // Valid flag: cleared outside the keep range, moved with the data.
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (ctl.offer) begin
      if (!in_range) begin
        valid <= 1'b0;
      end else if (prev_take) begin
        valid <= prev_valid;
      end else if (take) begin
        valid <= 1'b1;
      end
    end else if (ctl.trim) begin
      if (!in_range) begin
        valid <= 1'b0;
      end
    end else if (ctl.shift_up) begin
      valid <= next_valid;
    end
  end

  // Entry data: insert here, take the upper neighbor, or the lower one.
  always_ff @(posedge clk) begin
    if (ctl.offer && in_range) begin
      if (prev_take) begin
        entry <= prev_entry;
      end else if (take) begin
        entry <= cand;
      end
    end else if (ctl.shift_up) begin
      entry <= next_entry;
    end
  end

endmodule

// ===== rtl/top_k_score_selector_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Top-k score selector
// Sorted shift chain of cells keeping the best k candidates, drained in
// rank order on a flush.
// ----------------------------------------------------------------------------
// Offers are taken one per cycle while idle; each cell compares in parallel
// and the candidate is in place in the cycle after acceptance.
// A flush stalls the input while the chain drains; the first result is
// shown the cycle after the flush, then one per cycle unless the result side
// stalls. The drain rate is set by the chain shifting up one cell per taken
// word.
// Reset empties every cell and sets keep_count to 16.
module top_k_score_selector_unit #(
  parameter int MAX_KEEP = tksel_pkg::MAX_KEEP_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cand_valid,
  output logic                  cand_stall,
  input  tksel_pkg::cand_word_t cand,
  output logic                  res_valid,
  input  logic                  res_stall,
  output tksel_pkg::res_word_t  res,
  input  logic                  cfg_we,
  input  logic [4:0]            cfg_wdata
);
  import tksel_pkg::*;

  logic [4:0]          keep_count;
  sel_state_t          state, state_next;
  cell_ctl_t           ctl;
  entry_t              cand_entry;
  logic [MAX_KEEP-1:0] cell_take;
  logic [MAX_KEEP-1:0] cell_valid;
  logic [MAX_KEEP-1:0] in_range;
  logic [MAX_KEEP:0]   valid_ext;
  entry_t              cell_entry [MAX_KEEP];

  // Keep count register.
  always_ff @(posedge clk) begin
    if (rst) begin
      keep_count <= KEEP_COUNT_RST;
    end else if (cfg_we) begin
      keep_count <= cfg_wdata;
    end
  end

  assign cand_entry.score  = cand.score;
  assign cand_entry.doc_id = cand.doc_id;
  assign valid_ext         = {1'b0, cell_valid};

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Sequencer: accept offers while idle, drain the chain after a flush.
  always_comb begin
    state_next   = state;
    cand_stall   = 1'b0;
    res_valid    = 1'b0;
    ctl.offer    = 1'b0;
    ctl.trim     = 1'b0;
    ctl.shift_up = 1'b0;
    unique case (state)
      ST_IDLE: begin
        if (cand_valid) begin
          if (cand.op == OP_FLUSH) begin
            ctl.trim   = 1'b1;
            state_next = ST_DRAIN;
          end else begin
            ctl.offer = 1'b1;
          end
        end
      end
      ST_DRAIN: begin
        cand_stall   = 1'b1;
        res_valid    = cell_valid[0];
        ctl.shift_up = cell_valid[0] & ~res_stall;
        if (!cell_valid[0]) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Result word comes straight from the head cell.
  assign res.out_doc_id = cell_entry[0].doc_id;
  assign res.out_score  = cell_entry[0].score;
  assign res.last       = ~valid_ext[1];

  // The chain of cells.
  for (genvar i = 0; i < MAX_KEEP; i++) begin : g_cell
    logic   prev_take, prev_valid;
    entry_t prev_entry, next_entry;

    assign in_range[i] = (i < int'(keep_count));

    if (i == 0) begin : g_head
      assign prev_take  = 1'b0;
      assign prev_valid = 1'b0;
      assign prev_entry = cand_entry;
    end else begin : g_body
      assign prev_take  = cell_take[i-1];
      assign prev_valid = cell_valid[i-1];
      assign prev_entry = cell_entry[i-1];
    end

    if (i == MAX_KEEP - 1) begin : g_tail
      assign next_entry = cell_entry[i];
    end else begin : g_mid
      assign next_entry = cell_entry[i+1];
    end

    tksel_cell u_cell (
      .clk        (clk),
      .rst        (rst),
      .ctl        (ctl),
      .cand       (cand_entry),
      .in_range   (in_range[i]),
      .prev_take  (prev_take),
      .prev_valid (prev_valid),
      .prev_entry (prev_entry),
      .next_valid (valid_ext[i+1]),
      .next_entry (next_entry),
      .take       (cell_take[i]),
      .valid      (cell_valid[i]),
      .entry      (cell_entry[i])
    );
  end

  // Occupied cells always form an unbroken run from the head.
  assert property (@(posedge clk) disable iff (rst)
    ((cell_valid + 1'b1) & cell_valid) == '0)
    else $error("Cell chain has a gap.");

  // A flush leaves nothing beyond the keep range.
  assert property (@(posedge clk) disable iff (rst)
    ctl.trim |=> (cell_valid & ~$past(in_range)) == '0)
    else $error("Entries beyond keep range survive a flush.");

  // An offer with a nonzero keep count always fills the head cell.
  assert property (@(posedge clk) disable iff (rst)
    (ctl.offer && keep_count != 5'd0) |=> cell_valid[0])
    else $error("Offer left the head cell empty.");

  // After the last word of a flush is taken, nothing more is shown.
  assert property (@(posedge clk) disable iff (rst)
    (res_valid && !res_stall && res.last) |=> !res_valid)
    else $error("Result shown after the last word.");

  // No input word is taken while the chain drains.
  assert property (@(posedge clk) disable iff (rst)
    res_valid |-> (cand_stall && !ctl.offer && !ctl.trim))
    else $error("Input taken during drain.");

endmodule
